// File: design/swrms_pkg.sv
// Shared constants, sizes and the window store request type of the
// sliding-window true-RMS meter. No dependencies.
`default_nettype none

package swrms_pkg;

   // Block size
   localparam int CHANNELS = 7;
   localparam int WINDOW   = 80;

   // Field widths
   localparam int CH_W      = 3;
   localparam int RAW_W     = 16;
   localparam int SAMPLE_W  = 12;
   localparam int RMS_W     = 12;
   localparam int ZERO_W    = 13;
   localparam int OFFSET_W  = 8;
   localparam int SUM_W     = 28;
   localparam int CSR_IDX_W = 1;

   // Derived sizes
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int DEPTH  = CHANNELS * WINDOW;
   localparam int ADDR_W = $clog2(DEPTH);

   // Sample path
   localparam int CODE_W           = 13;
   localparam int DIFF_W           = 14;
   localparam int MAG_W            = 13;
   localparam int QMAG_W           = 11;
   localparam int LEFT_ALIGN_LIMIT = 4096;
   localparam int SCALE_Q16        = 23383;
   localparam int SAMPLE_LIMIT     = 1462;

   // Shared multiplier and root search
   localparam int MUL_W     = 16;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int ROOT_BITS = 11;
   localparam int BIT_W     = $clog2(ROOT_BITS);
   localparam int ODD_W     = ROOT_BITS + 1;
   localparam int LHS_W     = SUM_W + 2;
   localparam int CMP_W     = 2 * ODD_W + 10;

   localparam longint unsigned SUM_MAX =
      longint'(WINDOW) * longint'(SAMPLE_LIMIT) * longint'(SAMPLE_LIMIT);

   // Reset values of the registers
   localparam logic [ZERO_W-1:0]   ZERO_RESET   = ZERO_W'(2048);
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(10);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_CODE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RMS_OFFSET = CSR_IDX_W'(1);

   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] wdata;
   } win_req_type;

endpackage

`default_nettype wire

// File: design/swrms_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on swrms_pkg for the operand width.
`default_nettype none

module swrms_mul (
   input  wire logic                        clock,
   input  wire logic [swrms_pkg::MUL_W-1:0]  mul_a,
   input  wire logic [swrms_pkg::MUL_W-1:0]  mul_b,
   output logic      [swrms_pkg::PROD_W-1:0] mul_p
);
   import swrms_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign mul_p   = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// File: design/swrms_window.sv
// Window sample store for all channels, with a clearing pass after reset.
// Depends on swrms_pkg for sizes and the request type.
`default_nettype none

module swrms_window (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire swrms_pkg::win_req_type         win_req,
   output logic      [swrms_pkg::SAMPLE_W-1:0] rd_data,
   output logic                               clr_busy
);
   import swrms_pkg::*;

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]   clr_cnt_ff;
   logic [ADDR_W-1:0]   clr_cnt_in;
   logic                clr_busy_ff;
   logic                clr_busy_in;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // Sweep zeros in while clearing, then take writes from the sequencer
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (win_req.wr_en) begin
         mem[win_req.addr] <= win_req.wdata;
      end
      if (win_req.rd_en) begin
         rd_data_ff <= mem[win_req.addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

`default_nettype wire

// File: design/sliding_window_true_rms_unit.sv
// Top level of the sliding-window true-RMS meter: sequencer, sums and ports.
// Depends on swrms_pkg, swrms_mul and swrms_window.
//
// Per-channel true-RMS meter. Each request item carries a raw converter word
// (tdata) and a channel number (tuser). A word above 4096 is taken as
// left-aligned and shifted right by 4; zero_code is subtracted, the difference
// is scaled by 0.35679742 volts per step and rounded half away from zero,
// saturating at +/-1462. The sample replaces the oldest of that channel's 80
// stored samples, the channel's sum of squares is updated, and the response
// item carries the channel, the sample and round(sqrt(sum / 79)) minus
// rms_offset, not clamped at zero. A channel of 7 changes no state and reports
// an RMS of zero. The next item is accepted only after the response of the
// current one has been posted to the response register. The root search is
// 11 bits wide and runs one result bit at a time on the one shared 16x16
// multiplier that also forms the scaled sample and both squares. After reset
// the window store is swept clear, one entry a cycle over all 560 entries,
// before the first item is taken; register writes are accepted throughout.
// The next item is accepted while a finished response still waits on
// rsp_tready.
`default_nettype none

module sliding_window_true_rms_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [swrms_pkg::RAW_W-1:0]        req_tdata,  // raw_code
   input  wire logic [swrms_pkg::CH_W-1:0]         req_tuser,  // channel
   // response channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [swrms_pkg::SAMPLE_W+swrms_pkg::RMS_W-1:0] rsp_tdata,
                                                  // sample_volts, rms_value
   output logic [swrms_pkg::CH_W-1:0]              rsp_tuser,  // channel_out
   // register write port
   input  wire logic                              csr_we,
   input  wire logic [swrms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [swrms_pkg::ZERO_W-1:0]       csr_wdata
);
   import swrms_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCALE,
      ST_OLD,
      ST_NEW,
      ST_SUM,
      ST_ROOT_SQ,
      ST_ROOT_CMP,
      ST_FINISH
   } state_type;

   // Sequencer and item registers
   state_type           state_ff,    state_in;
   logic [CH_W-1:0]     ch_ff,       ch_in;
   logic [RAW_W-1:0]    raw_ff,      raw_in;
   logic [MAG_W-1:0]    dmag_ff,     dmag_in;
   logic                neg_ff,      neg_in;
   logic [SLOT_W-1:0]   slot_ff,     slot_in;
   logic [SAMPLE_W-1:0] old_mag_ff,  old_mag_in;
   logic [SAMPLE_W-1:0] sample_ff,   sample_in;
   logic [QMAG_W-1:0]   smag_ff,     smag_in;
   logic [SUM_W-1:0]    part_ff,     part_in;
   logic [LHS_W-1:0]    lhs_ff,      lhs_in;
   logic [ROOT_BITS-1:0] root_ff,    root_in;
   logic [BIT_W-1:0]    bit_ff,      bit_in;

   // Configuration
   logic [ZERO_W-1:0]   zero_ff,     zero_in;
   logic [OFFSET_W-1:0] offset_ff,   offset_in;

   // Per-channel state
   logic [SUM_W-1:0]    sum_ff  [CHANNELS];
   logic [SLOT_W-1:0]   wslot_ff[CHANNELS];
   logic                chan_we;
   logic [SUM_W-1:0]    sum_new;
   logic [SLOT_W-1:0]   slot_next;

   // Response registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]     rsp_ch_ff,    rsp_ch_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [RMS_W-1:0]    rsp_rms_ff,   rsp_rms_in;

   // Datapath nets
   logic                ch_valid;
   logic [SLOT_W-1:0]   slot_cur;
   logic [ADDR_W-1:0]   base_addr;
   logic [CODE_W-1:0]   code;
   logic [DIFF_W-1:0]   diff;
   logic [DIFF_W-1:0]   diff_neg;
   logic [SAMPLE_W-1:0] rd_neg;
   logic [SUM_W:0]      rnd;
   logic [MAG_W-1:0]    qraw;
   logic [QMAG_W-1:0]   qsat;
   logic [ROOT_BITS-1:0] cand;
   logic [ODD_W-1:0]    odd;
   logic [CMP_W-1:0]    scaled_sq;
   logic [MUL_W-1:0]    mul_a;
   logic [MUL_W-1:0]    mul_b;
   logic [PROD_W-1:0]   mul_p;
   win_req_type         win_req;
   logic [SAMPLE_W-1:0] rd_data;
   logic                clr_busy;

   swrms_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   swrms_window u_window (
      .clock    (clock),
      .reset    (reset),
      .win_req  (win_req),
      .rd_data  (rd_data),
      .clr_busy (clr_busy)
   );

   assign ch_valid  = 32'(ch_ff) < CHANNELS;
   assign slot_cur  = ch_valid ? wslot_ff[ch_ff] : '0;
   assign base_addr = ADDR_W'(ch_ff) * ADDR_W'(WINDOW);

   // Undo left alignment, then take the offset from the zero code
   assign code     = (raw_ff > RAW_W'(LEFT_ALIGN_LIMIT)) ? CODE_W'(raw_ff >> 4)
                                                          : CODE_W'(raw_ff);
   assign diff     = DIFF_W'(code) - DIFF_W'(zero_ff);
   assign diff_neg = -diff;
   assign rd_neg   = -rd_data;

   // Round the Q16 product half away from zero and saturate the magnitude
   assign rnd  = (SUM_W + 1)'(mul_p[SUM_W-1:0]) + (SUM_W + 1)'(32768);
   assign qraw = rnd[SUM_W:16];
   assign qsat = (qraw > MAG_W'(SAMPLE_LIMIT)) ? QMAG_W'(SAMPLE_LIMIT)
                                               : QMAG_W'(qraw);

   // Root trial: keep candidate bit when (WINDOW-1)*(2c-1)^2 <= 4*sum
   assign cand      = root_ff | (ROOT_BITS'(1) << bit_ff);
   assign odd       = {cand, 1'b0} - ODD_W'(1);
   assign scaled_sq = CMP_W'(mul_p[2*ODD_W-1:0]) * CMP_W'(WINDOW - 1);

   assign sum_new   = part_ff + SUM_W'(mul_p);
   assign slot_next = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + SLOT_W'(1);

   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      raw_in        = raw_ff;
      dmag_in       = dmag_ff;
      neg_in        = neg_ff;
      slot_in       = slot_ff;
      old_mag_in    = old_mag_ff;
      sample_in     = sample_ff;
      smag_in       = smag_ff;
      part_in       = part_ff;
      lhs_in        = lhs_ff;
      root_in       = root_ff;
      bit_in        = bit_ff;
      zero_in       = zero_ff;
      offset_in     = offset_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_ch_in     = rsp_ch_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_rms_in    = rsp_rms_ff;
      chan_we       = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      win_req       = '0;

      if (csr_we) begin
         if (csr_index == CSR_ZERO_CODE) begin
            zero_in = csr_wdata;
         end
         if (csr_index == CSR_RMS_OFFSET) begin
            offset_in = csr_wdata[OFFSET_W-1:0];
         end
      end

      // Drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               ch_in    = req_tuser;
               raw_in   = req_tdata;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // Fetch the oldest sample of the channel's ring
            neg_in        = diff[DIFF_W-1];
            dmag_in       = diff[DIFF_W-1] ? MAG_W'(diff_neg) : MAG_W'(diff);
            slot_in       = slot_cur;
            win_req.rd_en = ch_valid;
            win_req.addr  = base_addr + ADDR_W'(slot_cur);
            state_in      = ST_SCALE;
         end
         ST_SCALE: begin
            mul_a      = MUL_W'(dmag_ff);
            mul_b      = MUL_W'(SCALE_Q16);
            old_mag_in = rd_data[SAMPLE_W-1] ? rd_neg : rd_data;
            state_in   = ST_OLD;
         end
         ST_OLD: begin
            smag_in   = qsat;
            sample_in = neg_ff ? -SAMPLE_W'(qsat) : SAMPLE_W'(qsat);
            mul_a     = MUL_W'(old_mag_ff);
            mul_b     = MUL_W'(old_mag_ff);
            state_in  = ST_NEW;
         end
         ST_NEW: begin
            // Retire the oldest square and overwrite its slot
            part_in       = ch_valid ? sum_ff[ch_ff] - SUM_W'(mul_p) : '0;
            mul_a         = MUL_W'(smag_ff);
            mul_b         = MUL_W'(smag_ff);
            win_req.wr_en = ch_valid;
            win_req.addr  = base_addr + ADDR_W'(slot_ff);
            win_req.wdata = sample_ff;
            state_in      = ST_SUM;
         end
         ST_SUM: begin
            chan_we  = ch_valid;
            lhs_in   = {sum_new, 2'b00};
            root_in  = '0;
            bit_in   = BIT_W'(ROOT_BITS - 1);
            state_in = ch_valid ? ST_ROOT_SQ : ST_FINISH;
         end
         ST_ROOT_SQ: begin
            mul_a    = MUL_W'(odd);
            mul_b    = MUL_W'(odd);
            state_in = ST_ROOT_CMP;
         end
         ST_ROOT_CMP: begin
            if (scaled_sq <= CMP_W'(lhs_ff)) begin
               root_in = cand;
            end
            if (bit_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               bit_in   = bit_ff - BIT_W'(1);
               state_in = ST_ROOT_SQ;
            end
         end
         ST_FINISH: begin
            // Hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_ch_in     = ch_ff;
               rsp_sample_in = sample_ff;
               rsp_rms_in    = ch_valid ? RMS_W'(root_ff) - RMS_W'(offset_ff) : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         zero_ff      <= ZERO_RESET;
         offset_ff    <= OFFSET_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i]   <= '0;
            wslot_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         zero_ff      <= zero_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
         if (chan_we) begin
            sum_ff[ch_ff]   <= sum_new;
            wslot_ff[ch_ff] <= slot_next;
         end
      end
      ch_ff         <= ch_in;
      raw_ff        <= raw_in;
      dmag_ff       <= dmag_in;
      neg_ff        <= neg_in;
      slot_ff       <= slot_in;
      old_mag_ff    <= old_mag_in;
      sample_ff     <= sample_in;
      smag_ff       <= smag_in;
      part_ff       <= part_in;
      lhs_ff        <= lhs_in;
      root_ff       <= root_in;
      bit_ff        <= bit_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_rms_ff    <= rsp_rms_in;
   end

   assign req_tready = (state_ff == ST_IDLE) && !clr_busy;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ch_ff;
   assign rsp_tdata  = {rsp_rms_ff, rsp_sample_ff};

   // An accepted item always starts the window fetch
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_LOAD))
      else $error("accepted item did not start processing");

   // A channel outside the block reports an RMS of zero
   a_bad_channel_rms: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (32'(rsp_tuser) >= CHANNELS)) |-> (rsp_tdata[SAMPLE_W+RMS_W-1:SAMPLE_W] == '0))
      else $error("out-of-range channel gave a non-zero RMS");

   // The running sum never exceeds a full window of saturated samples
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ROOT_SQ) && ch_valid) |-> (64'(sum_ff[ch_ff]) <= SUM_MAX))
      else $error("square sum beyond a full window of limit samples");

   // No item is taken while the window store is still being cleared
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> (state_ff == ST_IDLE))
      else $error("item in flight during the clearing pass");

endmodule

`default_nettype wire
